/* hw/rtl/sixcal_pkg.sv */
// ----------------------------------------------------------------------------
// sixcal_pkg
// Shared types and codes of the six-pose IMU calibrator.
// ----------------------------------------------------------------------------
package sixcal_pkg;

    typedef enum logic [0:0] {
        CFG_TRANSITION = 1'b0,
        CFG_MEASURING  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_TRANS = 2'd1,
        EV_MEAS  = 2'd2,
        EV_DONE  = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRANS = 2'd1,
        PH_MEAS  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        T_IDLE,
        T_WAIT,
        T_EMIT
    } t_top_st;

    typedef enum logic [3:0] {
        L_IDLE,
        L_UPREP,
        L_USTART,
        L_UDIV,
        L_UMEAN,
        L_UD2,
        L_UPROD,
        L_UACC,
        L_FSCAN,
        L_FCALC,
        L_FSTART1,
        L_FDIV1,
        L_FSTART2,
        L_FDIV2
    } t_lane_st;

    typedef struct packed {
        logic clear;
        logic upd;
        logic fin;
    } t_lane_ctl;

    typedef struct packed {
        logic               op;
        logic [31:0]        time_ms;
        logic signed [15:0] acc_x_sample;
        logic signed [15:0] acc_y_sample;
        logic signed [15:0] acc_z_sample;
        logic signed [15:0] gyro_x_sample;
        logic signed [15:0] gyro_y_sample;
        logic signed [15:0] gyro_z_sample;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [1:0]         phase;
        logic [2:0]         pose_index;
        logic [1:0]         axis;
        logic signed [31:0] acc_bias;
        logic [31:0]        acc_scale;
        logic signed [31:0] gyro_bias;
        logic [47:0]        acc_var;
        logic [47:0]        gyro_var;
        logic               last;
    } t_out_item;

    localparam logic [31:0] TRANSITION_RESET = 32'd5000;
    localparam logic [31:0] MEASURING_RESET  = 32'd5000;
    localparam logic [47:0] M2_MAX           = {48{1'b1}};
    localparam logic [47:0] SCALE_NUMER      = 48'h8000_0000_0000;

endpackage

/* hw/rtl/sixcal_div.sv */
// ----------------------------------------------------------------------------
// sixcal_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sixcal_div #(
    parameter int DW = 48,
    parameter int VW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quot,
    output logic          o_done
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quot;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   w_sh;
    logic          w_ge;
    logic [VW:0]   w_sub;

    assign w_sh  = {r_rem, r_quot[DW-1]};
    assign w_ge  = (w_sh >= {1'b0, r_div});
    assign w_sub = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[VW-1:0] : w_sh[VW-1:0];
            r_quot <= {r_quot[DW-2:0], w_ge};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

/* hw/rtl/sixcal_lane.sv */
// ----------------------------------------------------------------------------
// sixcal_lane
// One axis: Welford updates of pose means and M2 sums, then bias, scale and
// variances for that axis.
// ----------------------------------------------------------------------------
module sixcal_lane import sixcal_pkg::*; #(
    parameter int NUM_POSES  = 6,
    parameter int COUNT_BITS = 24,
    localparam int PIW       = $clog2(NUM_POSES),
    localparam int TW        = COUNT_BITS + 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic [PIW-1:0]     i_pose,
    input  logic [COUNT_BITS-1:0] i_n,
    input  logic [TW-1:0]      i_tm1,
    input  logic signed [15:0] i_acc,
    input  logic signed [15:0] i_gyro,
    output logic               o_busy,
    output logic signed [31:0] o_acc_bias,
    output logic [31:0]        o_acc_scale,
    output logic signed [31:0] o_gyro_bias,
    output logic [47:0]        o_acc_var,
    output logic [47:0]        o_gyro_var
);

    localparam int VW = (TW > 33) ? TW : 33;

    t_lane_st r_state, n_state;

    logic signed [31:0] r_means [NUM_POSES];
    logic signed [31:0] r_gmean;
    logic [47:0]        r_acc_m2, r_gyro_m2;
    logic [PIW-1:0]     r_pose, r_scan;
    logic [VW-1:0]      r_n, r_tm1;
    logic signed [31:0] r_xa, r_xg;
    logic signed [32:0] r_d1a, r_d1g;
    logic signed [33:0] r_nma, r_nmg;
    logic [31:0]        r_d2a, r_d2g;
    logic [63:0]        r_pa, r_pg;
    logic signed [31:0] r_mx, r_mn;
    logic [32:0]        r_span;
    logic signed [31:0] r_bias;
    logic [31:0]        r_scale;
    logic [47:0]        r_avar, r_gvar;

    logic [PIW-1:0]     w_rd_idx;
    logic signed [31:0] w_mean;
    logic [31:0]        w_d1a_mag, w_d1g_mag;
    logic               w_start_a, w_start_b;
    logic [47:0]        w_dvd_a, w_dvd_b, w_q_a, w_q_b;
    logic [VW-1:0]      w_dvs_a, w_dvs_b;
    logic               w_done_a, w_done_b;
    logic signed [33:0] w_sq_a, w_sq_g, w_d2a, w_d2g;
    logic signed [32:0] w_sum;
    logic [48:0]        w_acc_s, w_gyro_s;

    assign w_rd_idx  = (r_state == L_FSCAN) ? r_scan : r_pose;
    assign w_mean    = r_means[w_rd_idx];
    assign w_d1a_mag = r_d1a[32] ? 32'(-r_d1a) : r_d1a[31:0];
    assign w_d1g_mag = r_d1g[32] ? 32'(-r_d1g) : r_d1g[31:0];
    assign w_sq_a    = r_d1a[32] ? -$signed({2'b00, w_q_a[31:0]}) : $signed({2'b00, w_q_a[31:0]});
    assign w_sq_g    = r_d1g[32] ? -$signed({2'b00, w_q_b[31:0]}) : $signed({2'b00, w_q_b[31:0]});
    assign w_d2a     = 34'(r_xa) - r_nma;
    assign w_d2g     = 34'(r_xg) - r_nmg;
    assign w_sum     = 33'(r_mx) + 33'(r_mn);
    assign w_acc_s   = {1'b0, r_acc_m2} + {1'b0, r_pa[63:16]};
    assign w_gyro_s  = {1'b0, r_gyro_m2} + {1'b0, r_pg[63:16]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: begin
                if (i_ctl.upd) n_state = L_UPREP;
                else if (i_ctl.fin) n_state = L_FSCAN;
            end
            L_UPREP:   n_state = L_USTART;
            L_USTART:  n_state = L_UDIV;
            L_UDIV:    if (w_done_a) n_state = L_UMEAN;
            L_UMEAN:   n_state = L_UD2;
            L_UD2:     n_state = L_UPROD;
            L_UPROD:   n_state = L_UACC;
            L_UACC:    n_state = L_IDLE;
            L_FSCAN:   if (r_scan == PIW'(NUM_POSES - 1)) n_state = L_FCALC;
            L_FCALC:   n_state = L_FSTART1;
            L_FSTART1: n_state = L_FDIV1;
            L_FDIV1:   if (w_done_a) n_state = L_FSTART2;
            L_FSTART2: n_state = L_FDIV2;
            L_FDIV2:   if (w_done_b) n_state = L_IDLE;
            default:   n_state = L_IDLE;
        endcase
    end

    always_comb begin
        o_busy    = (r_state != L_IDLE);
        w_start_a = (r_state == L_USTART) || (r_state == L_FSTART1);
        w_start_b = w_start_a || (r_state == L_FSTART2);
        w_dvd_a   = {16'd0, w_d1a_mag};
        w_dvs_a   = r_n;
        w_dvd_b   = {16'd0, w_d1g_mag};
        w_dvs_b   = r_n;
        if (r_state == L_FSTART1) begin
            w_dvd_a = SCALE_NUMER;
            w_dvs_a = (r_span == '0) ? VW'(1) : VW'(r_span);
            w_dvd_b = r_acc_m2;
            w_dvs_b = r_tm1;
        end else if (r_state == L_FSTART2) begin
            w_dvd_b = r_gyro_m2;
            w_dvs_b = r_tm1;
        end
    end

    sixcal_div #(.DW(48), .VW(VW)) u_div_a (
        .i_clk, .i_rst_n, .i_start(w_start_a), .i_dividend(w_dvd_a),
        .i_divisor(w_dvs_a), .o_quot(w_q_a), .o_done(w_done_a)
    );

    sixcal_div #(.DW(48), .VW(VW)) u_div_b (
        .i_clk, .i_rst_n, .i_start(w_start_b), .i_dividend(w_dvd_b),
        .i_divisor(w_dvs_b), .o_quot(w_q_b), .o_done(w_done_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == L_IDLE && i_ctl.clear)) begin
            for (int i = 0; i < NUM_POSES; i++) r_means[i] <= '0;
            r_gmean   <= '0;
            r_acc_m2  <= '0;
            r_gyro_m2 <= '0;
        end else if (r_state == L_UACC) begin
            r_means[r_pose] <= r_nma[31:0];
            r_gmean         <= r_nmg[31:0];
            r_acc_m2        <= w_acc_s[48] ? M2_MAX : w_acc_s[47:0];
            r_gyro_m2       <= w_gyro_s[48] ? M2_MAX : w_gyro_s[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                r_pose <= i_pose;
                r_n    <= VW'(i_n);
                r_tm1  <= VW'(i_tm1);
                r_xa   <= {i_acc, 16'd0};
                r_xg   <= {i_gyro, 16'd0};
                r_scan <= '0;
            end
            L_UPREP: begin
                r_d1a <= 33'(r_xa) - 33'(w_mean);
                r_d1g <= 33'(r_xg) - 33'(r_gmean);
            end
            L_UMEAN: begin
                r_nma <= 34'(w_mean) + w_sq_a;
                r_nmg <= 34'(r_gmean) + w_sq_g;
            end
            L_UD2: begin
                r_d2a <= w_d2a[33] ? 32'(-w_d2a) : w_d2a[31:0];
                r_d2g <= w_d2g[33] ? 32'(-w_d2g) : w_d2g[31:0];
            end
            L_UPROD: begin
                r_pa <= 64'(w_d1a_mag) * 64'(r_d2a);
                r_pg <= 64'(w_d1g_mag) * 64'(r_d2g);
            end
            L_FSCAN: begin
                if (r_scan == '0) begin
                    r_mx <= w_mean;
                    r_mn <= w_mean;
                end else begin
                    if (w_mean > r_mx) r_mx <= w_mean;
                    if (w_mean < r_mn) r_mn <= w_mean;
                end
                r_scan <= r_scan + 1'b1;
            end
            L_FCALC: begin
                r_bias <= 32'((w_sum + 33'(w_sum[32])) >>> 1);
                r_span <= 33'(33'(r_mx) - 33'(r_mn));
            end
            L_FDIV1: begin
                if (w_done_a) begin
                    r_scale <= (r_span == '0 || w_q_a[47:32] != '0) ? '1 : w_q_a[31:0];
                    r_avar  <= w_q_b;
                end
            end
            L_FDIV2: begin
                if (w_done_b) r_gvar <= w_q_b;
            end
            default: begin
            end
        endcase
    end

    assign o_acc_bias  = r_bias;
    assign o_acc_scale = r_scale;
    assign o_gyro_bias = r_gmean;
    assign o_acc_var   = r_avar;
    assign o_gyro_var  = r_gvar;

endmodule

/* hw/rtl/six_position_imu_calibrator_core.sv */
// ----------------------------------------------------------------------------
// six_position_imu_calibrator_core
// Six-pose accelerometer and gyroscope calibration with one lane per axis.
//
//   channel   signals                           direction
//   in        i_in_valid  o_in_ready  i_in      sample, tick or start item
//   out       o_out_valid i_out_ready o_out     result item
//   cfg       i_cfg_valid o_cfg_ready i_cfg_*   register write
//
// a sample inside a window holds the input until the lanes finish its update, a divider pass included
// the window end of the last pose keeps the lanes busy with a scan of the pose means
// and two divider passes per lane, then one result item per axis is sent
// other items send at most one result item
// reset is synchronous and clears all calibration state
// a stalled output holds its item; input reopens once the last item of an event is loaded, even while it waits
// ----------------------------------------------------------------------------
module six_position_imu_calibrator_core import sixcal_pkg::*; #(
    parameter int NUM_POSES  = 6,
    parameter int NUM_AXES   = 3,
    parameter int COUNT_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_reg    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int PW  = $clog2(NUM_POSES + 1);
    localparam int PIW = $clog2(NUM_POSES);
    localparam int TW  = COUNT_BITS + 3;
    localparam int AW  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    t_top_st r_state, n_state;

    logic [31:0]           r_trans_ms, r_meas_ms, r_ws;
    t_phase                r_phase;
    logic [PW-1:0]         r_pose;
    logic [COUNT_BITS-1:0] r_samples;
    t_event                r_ev;
    logic [AW-1:0]         r_ax;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_acc_in, w_active, w_load, w_last;
    logic [31:0]           w_ws_eff, w_elapsed;
    logic                  w_trans_end, w_meas_end, w_sample, w_more;
    logic [PW-1:0]         w_pose_inc;
    logic [COUNT_BITS-1:0] w_n_new;
    logic [TW-1:0]         w_total, w_tm1;
    t_lane_ctl             w_ctl;
    logic [NUM_AXES-1:0]   w_busy;
    t_out_item             w_out;

    logic signed [15:0] w_acc_s  [3];
    logic signed [15:0] w_gyro_s [3];
    logic signed [31:0] w_abias  [NUM_AXES];
    logic [31:0]        w_scale  [NUM_AXES];
    logic signed [31:0] w_gbias  [NUM_AXES];
    logic [47:0]        w_avar   [NUM_AXES];
    logic [47:0]        w_gvar   [NUM_AXES];

    assign w_acc_s[0]  = i_in.acc_x_sample;
    assign w_acc_s[1]  = i_in.acc_y_sample;
    assign w_acc_s[2]  = i_in.acc_z_sample;
    assign w_gyro_s[0] = i_in.gyro_x_sample;
    assign w_gyro_s[1] = i_in.gyro_y_sample;
    assign w_gyro_s[2] = i_in.gyro_z_sample;

    assign o_cfg_ready = 1'b1;
    assign w_acc_in    = i_in_valid && o_in_ready;
    assign w_active    = (r_phase == PH_TRANS) || (r_phase == PH_MEAS);
    assign w_ws_eff    = (r_ws == '0) ? i_in.time_ms : r_ws;
    assign w_elapsed   = i_in.time_ms - w_ws_eff;
    assign w_trans_end = (r_phase == PH_TRANS) && (w_elapsed >= r_trans_ms);
    assign w_sample    = (r_phase == PH_MEAS) && (w_elapsed < r_meas_ms);
    assign w_meas_end  = (r_phase == PH_MEAS) && (w_elapsed >= r_meas_ms);
    assign w_pose_inc  = r_pose + 1'b1;
    assign w_more      = (w_pose_inc < PW'(NUM_POSES));
    assign w_n_new     = (r_samples != '1) ? r_samples + 1'b1 : r_samples;
    assign w_total     = TW'(r_samples) * TW'(NUM_POSES);
    assign w_tm1       = (w_total < TW'(2)) ? TW'(1) : w_total - 1'b1;

    always_comb begin
        w_ctl       = '0;
        w_ctl.clear = w_acc_in && i_in.op;
        w_ctl.upd   = w_acc_in && !i_in.op && w_sample;
        w_ctl.fin   = w_acc_in && !i_in.op && w_meas_end && !w_more;
    end

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : g_lane
            sixcal_lane #(.NUM_POSES(NUM_POSES), .COUNT_BITS(COUNT_BITS)) u_lane (
                .i_clk, .i_rst_n,
                .i_ctl(w_ctl),
                .i_pose(r_pose[PIW-1:0]),
                .i_n(w_n_new),
                .i_tm1(w_tm1),
                .i_acc(w_acc_s[g]),
                .i_gyro(w_gyro_s[g]),
                .o_busy(w_busy[g]),
                .o_acc_bias(w_abias[g]),
                .o_acc_scale(w_scale[g]),
                .o_gyro_bias(w_gbias[g]),
                .o_acc_var(w_avar[g]),
                .o_gyro_var(w_gvar[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (w_acc_in) begin
                    if (i_in.op) n_state = T_EMIT;
                    else if (w_trans_end) n_state = T_EMIT;
                    else if (w_sample) n_state = T_WAIT;
                    else if (w_meas_end) n_state = w_more ? T_EMIT : T_WAIT;
                end
            end
            T_WAIT: begin
                if (w_busy == '0) n_state = (r_ev == EV_DONE) ? T_EMIT : T_IDLE;
            end
            T_EMIT: begin
                if (w_load && w_last) n_state = T_IDLE;
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == T_IDLE);
        w_load     = (r_state == T_EMIT) && (!r_out_valid || i_out_ready);
        w_last     = (r_ev != EV_DONE) || (r_ax == AW'(NUM_AXES - 1));
    end

    always_comb begin
        w_out            = '0;
        w_out.event_res  = r_ev;
        w_out.phase      = r_phase;
        w_out.pose_index = r_pose[2:0];
        w_out.last       = w_last;
        if (r_ev == EV_DONE) begin
            w_out.axis      = 2'(r_ax);
            w_out.acc_bias  = w_abias[r_ax];
            w_out.acc_scale = w_scale[r_ax];
            w_out.gyro_bias = w_gbias[r_ax];
            w_out.acc_var   = w_avar[r_ax];
            w_out.gyro_var  = w_gvar[r_ax];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_trans_ms  <= TRANSITION_RESET;
            r_meas_ms   <= MEASURING_RESET;
            r_phase     <= PH_IDLE;
            r_pose      <= '0;
            r_ws        <= '0;
            r_samples   <= '0;
            r_ev        <= EV_NONE;
            r_ax        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TRANSITION: r_trans_ms <= i_cfg_data;
                    CFG_MEASURING:  r_meas_ms  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_acc_in) begin
                r_ax <= '0;
                if (i_in.op) begin
                    r_phase   <= PH_TRANS;
                    r_pose    <= '0;
                    r_ws      <= '0;
                    r_samples <= '0;
                    r_ev      <= EV_TRANS;
                end else if (w_active) begin
                    if (w_trans_end) begin
                        r_phase   <= PH_MEAS;
                        r_ws      <= i_in.time_ms;
                        r_samples <= '0;
                        r_ev      <= EV_MEAS;
                    end else if (w_sample) begin
                        r_ws      <= w_ws_eff;
                        r_samples <= w_n_new;
                        r_ev      <= EV_NONE;
                    end else if (w_meas_end && w_more) begin
                        r_phase <= PH_TRANS;
                        r_pose  <= w_pose_inc;
                        r_ws    <= i_in.time_ms;
                        r_ev    <= EV_TRANS;
                    end else if (w_meas_end) begin
                        r_ws    <= w_ws_eff;
                        r_phase <= PH_DONE;
                        r_pose  <= PW'(NUM_POSES);
                        r_ev    <= EV_DONE;
                    end else begin
                        r_ws <= w_ws_eff;
                        r_ev <= EV_NONE;
                    end
                end else begin
                    r_ev <= EV_NONE;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_ax        <= r_ax + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_busy) == 0) || ($countones(w_busy) == NUM_AXES))
        else $error("lanes out of step");

    a_idle_lanes_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_IDLE) |-> (w_busy == '0))
        else $error("lane busy while idle");

    a_meas_pose_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MEAS) |-> (r_pose < PW'(NUM_POSES)))
        else $error("pose out of range while measuring");

    a_emit_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_EMIT) |-> (r_ev != EV_NONE))
        else $error("emitting without event");

    a_wait_starts_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == T_WAIT)) |-> (w_busy != '0))
        else $error("wait entered without lane work");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the six-pose IMU calibrator: a queue-fed driver
// sends register writes, starts, ticks and samples with random gaps, a
// monitor with random stalls checks every result against a built-in
// fixed point model of the calibration sequence.
// ----------------------------------------------------------------------------
module tb_top;
    import sixcal_pkg::*;

    typedef struct {
        logic        is_cfg;
        t_cfg_reg    idx;
        logic [31:0] data;
        t_in_item    item;
    } t_pend;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    in_data = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_item   o_out;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_reg    cfg_idx = CFG_TRANSITION;
    logic [31:0] cfg_data = '0;

    six_position_imu_calibrator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pend     pend[$];
    t_out_item result_q[$];
    int        in_iss = 0, in_acc = 0, cfg_iss = 0, cfg_acc = 0;
    int        out_acc = 0, out_seen = 0;
    int        in_wait = 0, out_stall = 0, quiet = 0;
    int        errors = 0;
    bit        in_burst = 0, out_burst = 0;

    // calibration model state
    logic [31:0]        trans_ms = TRANSITION_RESET;
    logic [31:0]        meas_ms  = MEASURING_RESET;
    t_phase             ph = PH_IDLE;
    logic [2:0]         pose = '0;
    logic [31:0]        wstart = '0;
    logic [23:0]        cnt = '0;
    logic signed [31:0] pmean[18];
    logic [47:0]        am2[3];
    logic signed [31:0] gmean[3];
    logic [47:0]        gm2[3];

    task automatic clear_cal();
        pose = '0;
        wstart = '0;
        cnt = '0;
        foreach (pmean[i]) pmean[i] = '0;
        for (int k = 0; k < 3; k++) begin
            am2[k] = '0;
            gmean[k] = '0;
            gm2[k] = '0;
        end
    endtask

    task automatic welford_upd(inout logic signed [31:0] mean, inout logic [47:0] m2,
                               input logic signed [15:0] x, input logic [23:0] n);
        longint xq, d1, nm, d2;
        longint unsigned a1, a2, add, s;
        xq = longint'(x) * 65536;
        d1 = xq - longint'(mean);
        nm = longint'(mean) + d1 / longint'({40'd0, n});
        d2 = xq - nm;
        a1 = (d1 < 0) ? -d1 : d1;
        a2 = (d2 < 0) ? -d2 : d2;
        add = (a1 * a2) >> 16;
        mean = nm[31:0];
        if (add > M2_MAX) add = M2_MAX;
        s = m2 + add;
        m2 = (s > M2_MAX) ? M2_MAX : s[47:0];
    endtask

    task automatic push_result(t_event ev, logic [1:0] ax, logic [31:0] ab, logic [31:0] sc,
                               logic [31:0] gb, logic [47:0] av, logic [47:0] gv, logic lst);
        t_out_item r;
        r.event_res = ev;
        r.phase = ph;
        r.pose_index = pose;
        r.axis = ax;
        r.acc_bias = ab;
        r.acc_scale = sc;
        r.gyro_bias = gb;
        r.acc_var = av;
        r.gyro_var = gv;
        r.last = lst;
        result_q.push_back(r);
    endtask

    task automatic calib_step(t_in_item it);
        logic [31:0] elapsed;
        longint unsigned total, sc;
        longint mx, mn, v, span;
        int p;
        logic signed [15:0] av[3], gv[3];
        av = '{it.acc_x_sample, it.acc_y_sample, it.acc_z_sample};
        gv = '{it.gyro_x_sample, it.gyro_y_sample, it.gyro_z_sample};
        if (it.op) begin
            clear_cal();
            ph = PH_TRANS;
            push_result(EV_TRANS, 0, 0, 0, 0, 0, 0, 1'b1);
            return;
        end
        if (ph != PH_TRANS && ph != PH_MEAS) return;
        if (wstart == 0) wstart = it.time_ms;
        elapsed = it.time_ms - wstart;
        if (ph == PH_TRANS) begin
            if (elapsed < trans_ms) return;
            ph = PH_MEAS;
            wstart = it.time_ms;
            cnt = '0;
            push_result(EV_MEAS, 0, 0, 0, 0, 0, 0, 1'b1);
            return;
        end
        if (elapsed < meas_ms) begin
            p = (pose < 6) ? pose : 0;
            if (cnt != 24'hFFFFFF) cnt++;
            for (int k = 0; k < 3; k++) begin
                welford_upd(pmean[p * 3 + k], am2[k], av[k], cnt);
                welford_upd(gmean[k], gm2[k], gv[k], cnt);
            end
            return;
        end
        pose++;
        if (pose < 6) begin
            ph = PH_TRANS;
            wstart = it.time_ms;
            push_result(EV_TRANS, 0, 0, 0, 0, 0, 0, 1'b1);
            return;
        end
        ph = PH_DONE;
        pose = 3'd6;
        total = longint'(cnt) * 6;
        if (total < 2) total = 2;
        for (int k = 0; k < 3; k++) begin
            mx = pmean[k];
            mn = pmean[k];
            for (int s = 1; s < 6; s++) begin
                v = pmean[s * 3 + k];
                if (v > mx) mx = v;
                if (v < mn) mn = v;
            end
            span = mx - mn;
            if (span <= 0) sc = 64'hFFFF_FFFF;
            else begin
                sc = (64'd1 << 47) / longint'(span);
                if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
            end
            v = (mx + mn) / 2;
            push_result(EV_DONE, k[1:0], v[31:0], sc[31:0], gmean[k],
                        48'(am2[k] / (total - 1)), 48'(gm2[k] / (total - 1)), k == 2);
        end
    endtask

    // acceptance and checking at the rising edge
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                calib_step(in_data);
                in_acc++;
            end
            if (cfg_valid && o_cfg_ready) begin
                if (cfg_idx == CFG_TRANSITION) trans_ms = cfg_data;
                else meas_ms = cfg_data;
                cfg_acc++;
            end
            if (o_out_valid && out_ready) begin
                out_acc++;
                if (result_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result item %p", o_out);
                end else begin
                    e = result_q.pop_front();
                    if (o_out.event_res !== e.event_res || o_out.phase !== e.phase ||
                        o_out.pose_index !== e.pose_index || o_out.axis !== e.axis ||
                        o_out.acc_bias !== e.acc_bias || o_out.acc_scale !== e.acc_scale ||
                        o_out.gyro_bias !== e.gyro_bias ||
                        o_out.acc_var !== e.acc_var ||
                        o_out.gyro_var !== e.gyro_var || o_out.last !== e.last) begin
                        errors++;
                        if (errors <= 10) $display("mismatch exp %p act %p", e, o_out);
                    end
                end
            end
            if (result_q.size() != 0 || in_iss != in_acc) quiet = 0;
            else quiet++;
        end
    end

    // driver, changes at the falling edge
    always @(negedge i_clk) begin
        logic nv, ncv;
        t_in_item np;
        int nw;
        if (i_rst_n) begin
            nv = in_valid;
            np = in_data;
            nw = in_wait;
            ncv = cfg_valid;
            if (cfg_valid && cfg_iss == cfg_acc) ncv = 1'b0;
            if (in_valid && in_iss == in_acc) begin
                nv = 1'b0;
                if ($urandom_range(0, 7) == 0) in_burst = !in_burst;
                nw = in_burst ? 0 : $urandom_range(0, 16);
            end
            if (!nv && !ncv) begin
                if (nw > 0) nw--;
                else if (pend.size() != 0 && !pend[0].is_cfg) begin
                    np = pend[0].item;
                    void'(pend.pop_front());
                    nv = 1'b1;
                    in_iss++;
                end else if (pend.size() != 0 && !cfg_valid && quiet >= 200) begin
                    cfg_idx <= pend[0].idx;
                    cfg_data <= pend[0].data;
                    void'(pend.pop_front());
                    ncv = 1'b1;
                    cfg_iss++;
                end
            end
            in_valid <= nv;
            in_data <= np;
            in_wait = nw;
            cfg_valid <= ncv;
            if (out_acc != out_seen) begin
                out_seen = out_acc;
                if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
                out_stall = out_burst ? 0 : $urandom_range(0, 16);
            end
            if (out_stall > 0) begin
                out_ready <= 1'b0;
                out_stall--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // stimulus generation
    logic [31:0] gen_trans, gen_meas;
    int          nitems = 0;

    task automatic add_cfg(t_cfg_reg idx, logic [31:0] d);
        t_pend p;
        p.is_cfg = 1'b1;
        p.idx = idx;
        p.data = d;
        p.item = '0;
        pend.push_back(p);
        if (idx == CFG_TRANSITION) gen_trans = d;
        else gen_meas = d;
    endtask

    task automatic add_item(logic op, logic [31:0] t, logic signed [15:0] s[6]);
        t_pend p;
        p.is_cfg = 1'b0;
        p.idx = CFG_TRANSITION;
        p.data = '0;
        p.item = '{op, t, s[0], s[1], s[2], s[3], s[4], s[5]};
        pend.push_back(p);
        nitems++;
    endtask

    // mode 0 clustered per pose, 1 extremes, 2 constant
    task automatic add_run(logic [31:0] t0, int mode, int cap, bit noise);
        logic signed [15:0] s[6];
        logic signed [15:0] base[6][6];
        logic [31:0] t, span;
        longint unsigned dur, len;
        int n, pi;
        foreach (base[i, j]) base[i][j] = $urandom;
        dur = longint'(gen_trans) + longint'(gen_meas) + 4;
        len = dur * 6 + 8;
        foreach (s[i]) s[i] = $urandom;
        add_item(1'b1, t0, s);
        t = t0;
        span = 0;
        n = 0;
        while (span < len && n < cap) begin
            t += $urandom_range(1, 3);
            span = t - t0;
            pi = (span / dur) % 6;
            foreach (s[i]) begin
                case (mode)
                    0: s[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                              : base[pi][i] + 16'($urandom_range(0, 63)) - 16'sd32;
                    1: s[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    default: s[i] = base[0][i];
                endcase
            end
            if (noise && $urandom_range(0, 29) == 0) add_item(1'b0, 32'd0, s);
            else if (noise && $urandom_range(0, 79) == 0) add_item(1'b1, t, s);
            else add_item(1'b0, t, s);
            n++;
        end
    endtask

    initial begin
        logic signed [15:0] z[6];
        foreach (z[i]) z[i] = $urandom;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick, time wrap with extreme samples, zero span
        add_cfg(CFG_TRANSITION, 32'd1);
        add_cfg(CFG_MEASURING, 32'd1);
        add_item(1'b0, 32'd100, z);
        add_run(32'hFFFF_FFF4, 1, 25, 0);
        add_item(1'b0, 32'd0, z);
        add_run(32'd0, 2, 25, 0);
        add_cfg(CFG_TRANSITION, 32'd0);
        add_cfg(CFG_MEASURING, 32'd0);
        add_run(32'd50, 0, 20, 0);
        add_cfg(CFG_TRANSITION, 32'hFFFF_FFFF);
        add_run(32'd7, 0, 8, 0);
        add_cfg(CFG_TRANSITION, 32'd2);
        add_cfg(CFG_MEASURING, 32'hFFFF_FFFF);
        add_run(32'd9, 0, 12, 0);

        while (nitems < 390) begin
            add_cfg(CFG_TRANSITION, $urandom_range(0, 5));
            add_cfg(CFG_MEASURING, $urandom_range(0, 12));
            add_run($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000),
                    0, 80, $urandom_range(0, 2) == 0);
        end

        while (pend.size() != 0 || in_iss != in_acc || cfg_iss != cfg_acc) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
